/* src/lin_response_receiver_top_assert.svh */
// Assertion macros shared by the LIN response receiver modules.
`ifndef LIN_RESPONSE_RECEIVER_TOP_ASSERT_SVH
`define LIN_RESPONSE_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lrr_pkg.sv */
// Package with types and constants of the LIN response receiver.
package lrr_pkg;

  localparam int LRR_FRAME_BYTES = 16;
  localparam int LRR_ECHO_COUNT  = 2;
  localparam int LRR_FIFO_DEPTH  = 4;

  localparam logic [9:0] LRR_TIMEOUT_RESET = 10'd30;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_NO_RESPONSE = 2'd0;
  localparam logic [1:0] ST_BAD         = 2'd1;
  localparam logic [1:0] ST_CLASSIC     = 2'd2;
  localparam logic [1:0] ST_ENHANCED    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic [7:0] rx_byte;
  } lrr_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [3:0] data_index;
    logic [3:0] frame_length;
    logic [7:0] checksum_byte;
    logic [1:0] status;
    logic [7:0] protected_id;
    logic       last;
  } lrr_result_t;

  // Results handed from the frame logic to the output queue in one cycle.
  typedef struct packed {
    logic [1:0]  count;
    lrr_result_t first;
    lrr_result_t second;
  } lrr_push_t;

endpackage

/* src/lrr_core.sv */
// Input register, frame state and checksum logic of the LIN response receiver.
module lrr_core
  import lrr_pkg::*;
#(
  parameter int FRAME_BYTES = LRR_FRAME_BYTES,
  parameter int ECHO_COUNT  = LRR_ECHO_COUNT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  lrr_item_t item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [9:0] cfg_data,
  input  logic      room,
  output lrr_push_t push
);

  `include "lin_response_receiver_top_assert.svh"

  localparam logic [4:0] ECHO_PLUS1 = 5'(ECHO_COUNT + 1);
  localparam logic [4:0] ECHO_W     = 5'(ECHO_COUNT);
  localparam logic [4:0] LIMIT      = 5'(FRAME_BYTES);

  logic       s1_valid;
  lrr_item_t  s1_item;
  logic [9:0] timeout;
  logic       receiving, receiving_next;
  logic [4:0] byte_count, byte_count_next;
  logic [9:0] idle_count, idle_count_next;
  logic [7:0] pid_reg, pid_reg_next;
  logic [7:0] enh_sum, enh_sum_next;
  logic [7:0] cls_sum, cls_sum_next;
  logic [7:0] held_byte, held_byte_next;
  logic       advance;

  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0, p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // End-around-carry add: fold the carry back into bit 0.
  function automatic logic [7:0] eac_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  function automatic lrr_result_t make_summary(input logic [4:0] cnt,
                                               input logic [7:0] crc,
                                               input logic [7:0] enh,
                                               input logic [7:0] cls,
                                               input logic [7:0] pid);
    lrr_result_t r;
    logic [4:0]  len;
    r = '0;
    r.result_kind  = KIND_SUMMARY;
    r.last         = 1'b1;
    r.protected_id = pid;
    len = cnt - ECHO_PLUS1;
    if (cnt <= ECHO_PLUS1) begin
      r.status = ST_NO_RESPONSE;
    end else begin
      r.frame_length  = len[3:0];
      r.checksum_byte = crc;
      if (~enh == crc) begin
        r.status = ST_ENHANCED;
      end else if (~cls == crc) begin
        r.status = ST_CLASSIC;
      end else begin
        r.status = ST_BAD;
      end
    end
    return r;
  endfunction

  assign advance    = s1_valid && room;
  assign item_ready = !s1_valid || room;
  assign cfg_ready  = 1'b1;

  always_comb begin
    lrr_result_t data_res;
    logic [4:0]  idx;
    receiving_next  = receiving;
    byte_count_next = byte_count;
    idle_count_next = idle_count;
    pid_reg_next    = pid_reg;
    enh_sum_next    = enh_sum;
    cls_sum_next    = cls_sum;
    held_byte_next  = held_byte;
    push            = '0;
    data_res        = '0;
    idx             = byte_count - ECHO_PLUS1;
    data_res.result_kind  = KIND_DATA;
    data_res.data_byte    = held_byte;
    data_res.data_index   = idx[3:0];
    data_res.protected_id = pid_reg;
    if (advance) begin
      unique case (s1_item.operation)
        OP_START: begin
          pid_reg_next    = make_pid(s1_item.frame_id);
          enh_sum_next    = make_pid(s1_item.frame_id);
          cls_sum_next    = '0;
          byte_count_next = '0;
          idle_count_next = '0;
          receiving_next  = 1'b1;
        end
        OP_BYTE: begin
          if (receiving) begin
            idle_count_next = '0;
            if (byte_count > ECHO_W) begin
              push.first   = data_res;
              push.count   = 2'd1;
              enh_sum_next = eac_add(enh_sum, held_byte);
              cls_sum_next = eac_add(cls_sum, held_byte);
            end
            held_byte_next  = s1_item.rx_byte;
            byte_count_next = byte_count + 5'd1;
            if (byte_count_next >= LIMIT) begin
              receiving_next = 1'b0;
              if (push.count == 2'd1) begin
                push.second = make_summary(byte_count_next, held_byte_next,
                                           enh_sum_next, cls_sum_next, pid_reg);
                push.count  = 2'd2;
              end else begin
                push.first = make_summary(byte_count_next, held_byte_next,
                                          enh_sum_next, cls_sum_next, pid_reg);
                push.count = 2'd1;
              end
            end
          end
        end
        OP_TICK: begin
          if (receiving) begin
            idle_count_next = idle_count + 10'd1;
            if (idle_count_next >= timeout) begin
              receiving_next = 1'b0;
              push.first = make_summary(byte_count, held_byte, enh_sum, cls_sum,
                                        pid_reg);
              push.count = 2'd1;
            end
          end
        end
        default: begin
          // unused code: drop the beat
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      timeout    <= LRR_TIMEOUT_RESET;
      receiving  <= 1'b0;
      byte_count <= '0;
      idle_count <= '0;
      pid_reg    <= '0;
      enh_sum    <= '0;
      cls_sum    <= '0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      receiving  <= receiving_next;
      byte_count <= byte_count_next;
      idle_count <= idle_count_next;
      pid_reg    <= pid_reg_next;
      enh_sum    <= enh_sum_next;
      cls_sum    <= cls_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    held_byte <= held_byte_next;
  end

  `LRR_ASSERT_NEXT(a_summary_closes, advance && push.count != 2'd0 && (push.count == 2'd2 ? push.second.last : push.first.last), !receiving, "summary pushed but frame still open")
  `LRR_ASSERT_NOW(a_no_push_stalled, !advance, push.count == 2'd0, "results pushed without an accepted beat")
  `LRR_ASSERT_NOW(a_pair_is_data_then_summary, push.count == 2'd2, push.first.result_kind == KIND_DATA && push.second.last, "two results out of order")

endmodule

/* src/lrr_out_fifo.sv */
// Small result queue that takes up to two results per cycle and hands out one.
module lrr_out_fifo
  import lrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lrr_push_t   push,
  output logic        room,
  output logic        result_valid,
  input  logic        result_ready,
  output lrr_result_t result
);

  `include "lin_response_receiver_top_assert.svh"

  localparam int PTR_W = $clog2(LRR_FIFO_DEPTH);
  localparam int CNT_W = $clog2(LRR_FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(LRR_FIFO_DEPTH - 2);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(LRR_FIFO_DEPTH);

  lrr_result_t       mem [LRR_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count, count_next;
  logic              pop;

  assign room         = count <= ROOM_MAX;
  assign result_valid = count != '0;
  assign result       = mem[rd_ptr];
  assign pop          = result_valid && result_ready;
  assign count_next   = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  `LRR_ASSERT_NOW(a_fifo_bound, 1'b1, count <= FULL, "result queue overflow")
  `LRR_ASSERT_NOW(a_push_needs_room, push.count != 2'd0, room, "push into a queue without room")

endmodule

/* src/lin_response_receiver_top.sv */
// Top level of the LIN slave response receiver.
//
// Watches one LIN slave response: a start beat carries the 6-bit frame id,
// from which the protected id (P0 at bit 6, P1 at bit 7) is formed; the
// classic sum is cleared and the enhanced sum starts from the protected
// id. Byte beats follow; the first ECHO_COUNT bytes are the echoed header
// and are skipped. Every later byte is held until the next byte arrives,
// then sent out as a data result and added to both end-around-carry sums.
// The byte still held when the frame closes is the checksum. The frame
// closes after the timeout register's count of tick beats without a byte,
// or when FRAME_BYTES bytes have arrived, and a summary result then reports
// length, checksum and status (enhanced match checked before classic). A
// start beat while a frame is open drops that frame silently; byte and tick
// beats while idle, and the unused operation code, yield nothing. Rate: one
// input beat per clock; a beat is registered, processed in one pass and its
// results land in a four-entry result queue that feeds the output.
// A byte beat that both confirms a data byte and closes the frame gives two
// result beats; input stalls only while fewer than two queue entries are
// free. The timeout register is written through the cfg channel, which is
// always ready, and should only change while the block is idle.
module lin_response_receiver_top
  import lrr_pkg::*;
#(
  parameter int FRAME_BYTES = LRR_FRAME_BYTES,
  parameter int ECHO_COUNT  = LRR_ECHO_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  lrr_item_t   item,
  output logic        result_valid,
  input  logic        result_ready,
  output lrr_result_t result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);

  lrr_push_t push;   // results of the beat processed this cycle
  logic      room;   // queue can take two more results

  // Register the beat, track the frame, form results.
  lrr_core #(
    .FRAME_BYTES (FRAME_BYTES),
    .ECHO_COUNT  (ECHO_COUNT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .room       (room),
    .push       (push)
  );

  // Hold results until the consumer takes them.
  lrr_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
